// ===== hw/rtl/windowed_sinc_bandpass_coeff_gen_defines.svh =====
// Assertion macros shared by the coefficient generator checker
`ifndef WINDOWED_SINC_BANDPASS_COEFF_GEN_DEFINES_SVH
`define WINDOWED_SINC_BANDPASS_COEFF_GEN_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define WSBCG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication
`define WSBCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ===== hw/rtl/wsbcg_pkg.sv =====
// Types and constants of the windowed-sinc band-pass coefficient generator
package wsbcg_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW_XY = 34;

    localparam logic signed [CW_XY-1:0] CORDIC_GAIN = 34'sd652032875;
    localparam logic signed [29:0] INV_PI = 30'sd341782638;
    localparam logic signed [CW_XY-1:0] W_A0 = 34'sd450971566;
    localparam logic signed [27:0] W_A2 = 28'sd85899346;
    localparam logic [15:0] CUTOFF_MAX = 16'h8000;

    localparam logic [1:0] REG_TAP_COUNT = 2'd0;
    localparam logic [1:0] REG_LOW_CUTOFF = 2'd1;
    localparam logic [1:0] REG_HIGH_CUTOFF = 2'd2;

    // arctangent of 2^-k in 32-bit fractions of a turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    // per-item control carried down the pipeline
    typedef struct packed {
        logic               valid;
        logic [6:0]         idx;
        logic               err;
        logic               center;
        logic               single;
        logic signed [16:0] hc;
        logic               mneg;
        logic [7:0]         mabs;
        logic [7:0]         dv;
    } ctx_t;

endpackage

// ===== hw/rtl/wsbcg_cordic.sv =====
// Pipelined rotation CORDIC: sine and cosine of a turn fraction, signed Q3.30
module wsbcg_cordic (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [31:0]                       phase,
    output logic signed [wsbcg_pkg::CW_XY-1:0] sin_out,
    output logic signed [wsbcg_pkg::CW_XY-1:0] cos_out
);
    import wsbcg_pkg::*;

    logic signed [CW_XY-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW_XY-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CW_XY-1:0] z_reg [0:CORDIC_STEPS];
    logic                    flip_reg [0:CORDIC_STEPS];

    logic [31:0] quarter;
    logic        flip_next;
    logic [31:0] folded;

    // fold into [-1/4, 1/4) turn, negate the results afterwards
    assign quarter = phase + 32'h4000_0000;
    assign flip_next = quarter[31];
    assign folded = flip_next ? phase + 32'h8000_0000 : phase;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= CW_XY'($signed(folded));
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [CW_XY-1:0] dx;
        logic signed [CW_XY-1:0] dy;
        logic signed [CW_XY-1:0] da;
        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign da = $signed({2'b00, ATAN_TURNS[k]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_reg[k][CW_XY-1])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - da;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + da;
                end
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    assign sin_out = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign cos_out = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];

endmodule

// ===== hw/rtl/windowed_sinc_bandpass_coeff_gen.sv =====
// Blackman-windowed band-pass FIR coefficient generator, top level
// While the output is not stalled it takes one tap index per clock and returns the
// coefficient of each, one result per clock in steady state. The pipeline runs the two 32-step
// restoring divider chains (window phase i/(L-1) and the sinc division by the tap offset)
// each in series with a 25-stage CORDIC, plus the window and product stages. A stalled
// output freezes the whole pipeline; tap_count and the cutoffs are taken when an item
// enters and must only change while no item is in flight.
module windowed_sinc_bandpass_coeff_gen #(
    parameter int MAX_TAPS = 128,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [6:0]                    tap_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [6:0]                    tap_index_out,
    output logic signed [COEFF_WIDTH-1:0] coefficient,
    output logic                          index_error,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import wsbcg_pkg::*;

    localparam int DIV_STEPS = 32;
    localparam int ST_SDIV = 29;
    localparam int ST_LAST = 64;
    localparam int F = COEFF_WIDTH - 1;
    localparam int SH = 60 - F;
    localparam int SUMW = 70;
    localparam int QW = SUMW - SH;
    localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (SH - 1);
    localparam logic signed [QW-1:0] QMAX = QW'((64'sd1 <<< F) - 64'sd1);
    localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

    logic adv;

    // configuration
    logic [7:0]  tap_count_reg;
    logic [15:0] low_cutoff_reg;
    logic [15:0] high_cutoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= 8'd64;
            low_cutoff_reg <= 16'd0;
            high_cutoff_reg <= 16'd16384;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TAP_COUNT:   tap_count_reg <= cfg_data[7:0];
                REG_LOW_CUTOFF:  low_cutoff_reg <= cfg_data;
                REG_HIGH_CUTOFF: high_cutoff_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 0: capture item and clamped configuration
    logic        v0_reg;
    logic [6:0]  i0_reg;
    logic [7:0]  l0_reg;
    logic [15:0] fl0_reg;
    logic [15:0] fh0_reg;
    logic [7:0]  l_next;

    assign l_next = ({3'b000, tap_count_reg} > 11'(MAX_TAPS)) ? 8'(MAX_TAPS) : tap_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i0_reg <= tap_index;
            l0_reg <= l_next;
            fl0_reg <= (low_cutoff_reg > CUTOFF_MAX) ? CUTOFF_MAX : low_cutoff_reg;
            fh0_reg <= (high_cutoff_reg > CUTOFF_MAX) ? CUTOFF_MAX : high_cutoff_reg;
        end
    end

    // stage 1: offset, sine phases, window divider start
    logic signed [9:0]  m_s;
    logic signed [9:0]  m_neg;
    logic signed [26:0] prod_h;
    logic signed [26:0] prod_l;
    logic [7:0]         dv_s;
    ctx_t               ctx_next;
    ctx_t               ctx_reg [1:ST_LAST];
    logic [31:0]        ph_h_reg;
    logic [31:0]        ph_l_reg;

    assign m_s = $signed({2'b00, i0_reg, 1'b0}) - $signed({2'b00, l0_reg}) + 10'sd1;
    assign m_neg = -m_s;
    assign prod_h = $signed({1'b0, fh0_reg}) * m_s;
    assign prod_l = $signed({1'b0, fl0_reg}) * m_s;
    assign dv_s = l0_reg - 8'd1;

    always_comb
    begin
        ctx_next.valid = v0_reg;
        ctx_next.idx = i0_reg;
        ctx_next.err = ({1'b0, i0_reg} >= l0_reg);
        ctx_next.center = (m_s == 10'sd0);
        ctx_next.single = (l0_reg == 8'd1);
        ctx_next.hc = $signed({1'b0, fh0_reg}) - $signed({1'b0, fl0_reg});
        ctx_next.mneg = m_s[9];
        ctx_next.mabs = m_s[9] ? m_neg[7:0] : m_s[7:0];
        ctx_next.dv = dv_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= ST_LAST; k++)
                ctx_reg[k] <= '0;
        end
        else if (adv)
        begin
            ctx_reg[1] <= ctx_next;
            for (int k = 2; k <= ST_LAST; k++)
                ctx_reg[k] <= ctx_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_h_reg <= {prod_h[16:0], 15'd0};
            ph_l_reg <= {prod_l[16:0], 15'd0};
        end
    end

    // window phase: i * 2^32 / (L-1), stages 1..33
    logic [7:0]  wrem_reg [0:DIV_STEPS];
    logic [31:0] wacc_reg [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // i == L-1 gives a full turn, which is phase 0
            wrem_reg[0] <= ({1'b0, i0_reg} == dv_s) ? 8'd0 : {1'b0, i0_reg};
            wacc_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_wdiv
        logic [8:0] t;
        logic       ge;
        assign t = {wrem_reg[j], wacc_reg[j][31]};
        assign ge = (t >= {1'b0, ctx_reg[1+j].dv});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                wrem_reg[j+1] <= ge ? 8'(t - {1'b0, ctx_reg[1+j].dv}) : t[7:0];
                wacc_reg[j+1] <= {wacc_reg[j][30:0], ge};
            end
        end
    end

    // sine CORDICs: results at stage 26
    logic signed [CW_XY-1:0] s_hi;
    logic signed [CW_XY-1:0] s_lo;
    logic signed [CW_XY-1:0] unused_ch;
    logic signed [CW_XY-1:0] unused_cl;

    wsbcg_cordic u_sin_hi (
        .clk(clk), .adv(adv), .phase(ph_h_reg), .sin_out(s_hi), .cos_out(unused_ch)
    );
    wsbcg_cordic u_sin_lo (
        .clk(clk), .adv(adv), .phase(ph_l_reg), .sin_out(s_lo), .cos_out(unused_cl)
    );

    // window CORDICs: results at stage 58
    logic [31:0]             ph1;
    logic [31:0]             ph2;
    logic signed [CW_XY-1:0] c1;
    logic signed [CW_XY-1:0] c2;
    logic signed [CW_XY-1:0] unused_s1;
    logic signed [CW_XY-1:0] unused_s2;

    assign ph1 = wacc_reg[DIV_STEPS];
    assign ph2 = {wacc_reg[DIV_STEPS][30:0], 1'b0};

    wsbcg_cordic u_cos_1 (
        .clk(clk), .adv(adv), .phase(ph1), .sin_out(unused_s1), .cos_out(c1)
    );
    wsbcg_cordic u_cos_2 (
        .clk(clk), .adv(adv), .phase(ph2), .sin_out(unused_s2), .cos_out(c2)
    );

    // sinc numerator: stages 27..29
    logic signed [CW_XY:0]  d_reg;
    logic signed [63:0]     n_reg;
    logic signed [64:0]     n_prod;
    logic [63:0]            n_abs;
    logic [7:0]             srem_reg [0:DIV_STEPS];
    logic [31:0]            sacc_reg [0:DIV_STEPS];
    logic                   ssgn_reg [0:DIV_STEPS];

    assign n_prod = d_reg * INV_PI;
    assign n_abs = n_reg[63] ? 64'(-n_reg) : 64'(n_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= s_hi - s_lo;
            n_reg <= $signed({n_prod[62:0], 1'b0});
            srem_reg[0] <= '0;
            sacc_reg[0] <= n_abs[61:30];
            ssgn_reg[0] <= n_reg[63] ^ ctx_reg[ST_SDIV-1].mneg;
        end
    end

    // divide by |m|, stages 29..61
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_sdiv
        logic [8:0] t;
        logic       ge;
        assign t = {srem_reg[j], sacc_reg[j][31]};
        assign ge = (t >= {1'b0, ctx_reg[ST_SDIV+j].mabs});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srem_reg[j+1] <= ge ? 8'(t - {1'b0, ctx_reg[ST_SDIV+j].mabs}) : t[7:0];
                sacc_reg[j+1] <= {sacc_reg[j][30:0], ge};
                ssgn_reg[j+1] <= ssgn_reg[j];
            end
        end
    end

    // window: stages 59..62
    logic signed [CW_XY-1:0] c1h_reg;
    logic signed [61:0]      p2_reg;
    logic signed [CW_XY-1:0] w_reg;
    logic signed [CW_XY-1:0] wd1_reg;
    logic signed [CW_XY-1:0] wd2_reg;
    logic signed [CW_XY-1:0] w_next;
    logic signed [61:0]      p2_shift;

    assign p2_shift = p2_reg >>> 30;
    assign w_next = ctx_reg[59].single ? (CW_XY'(1) <<< 30)
                                       : W_A0 - c1h_reg + p2_shift[CW_XY-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1h_reg <= c1 >>> 1;
            p2_reg <= c2 * W_A2;
            w_reg <= w_next;
            wd1_reg <= w_reg;
            wd2_reg <= wd1_reg;
        end
    end

    // raw tap at stage 62, product 63..64, output at 65
    logic signed [CW_XY-1:0] h_reg;
    logic signed [CW_XY-1:0] hq;
    logic signed [CW_XY-1:0] hc_ext;
    logic signed [51:0]      phi_reg;
    logic signed [50:0]      plo_reg;
    logic signed [SUMW-1:0]  sum;
    logic signed [SUMW-1:0]  sum_sh;
    logic signed [QW-1:0]    q_reg;

    assign hq = $signed({2'b00, sacc_reg[DIV_STEPS]});
    assign hc_ext = CW_XY'(ctx_reg[61].hc) <<< 15;
    assign sum = (SUMW'(phi_reg) <<< 16) + SUMW'(plo_reg) + RND;
    assign sum_sh = sum >>> SH;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (ctx_reg[61].center)
                h_reg <= hc_ext;
            else
                h_reg <= ssgn_reg[DIV_STEPS] ? -hq : hq;
            phi_reg <= h_reg * $signed(wd2_reg[CW_XY-1:16]);
            plo_reg <= h_reg * $signed({1'b0, wd2_reg[15:0]});
            q_reg <= sum_sh[QW-1:0];
        end
    end

    logic signed [COEFF_WIDTH-1:0] coef_next;

    always_comb
    begin
        if (ctx_reg[ST_LAST].err)
            coef_next = '0;
        else if (q_reg > QMAX)
            coef_next = QMAX[COEFF_WIDTH-1:0];
        else if (q_reg < QMIN)
            coef_next = QMIN[COEFF_WIDTH-1:0];
        else
            coef_next = q_reg[COEFF_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= ctx_reg[ST_LAST].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tap_index_out <= ctx_reg[ST_LAST].idx;
            coefficient <= coef_next;
            index_error <= ctx_reg[ST_LAST].err;
        end
    end

endmodule

// ===== hw/rtl/wsbcg_checker.sv =====
// Port-level checks for the coefficient generator, bound to the top level
`include "windowed_sinc_bandpass_coeff_gen_defines.svh"

module wsbcg_checker #(
    parameter int COEFF_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [6:0]                    tap_index_out,
    input logic signed [COEFF_WIDTH-1:0] coefficient,
    input logic                          index_error
);

    `WSBCG_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid)
    `WSBCG_ASSERT_NEXT(a_out_payload_holds, out_valid && out_stall,
        $stable(coefficient) && $stable(tap_index_out))
    `WSBCG_ASSERT_NOW(a_err_zero_coef, out_valid && index_error, coefficient == '0)
    `WSBCG_ASSERT_NOW(a_blocked_stalls_input, out_valid && out_stall, in_stall)
    `WSBCG_ASSERT_NOW(a_free_output_no_stall, !out_valid || !out_stall, !in_stall)

endmodule

bind windowed_sinc_bandpass_coeff_gen wsbcg_checker #(
    .COEFF_WIDTH(COEFF_WIDTH)
) u_wsbcg_checker (.*);

// ===== tb/sv/windowed_sinc_bandpass_coeff_gen_tb.sv =====
// Testbench for the windowed-sinc band-pass coefficient generator
module windowed_sinc_bandpass_coeff_gen_tb;
    import wsbcg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 66;
    localparam int TAPS_LIMIT = 128;
    localparam int CWIDTH = 16;
    localparam longint CYCLE_LIMIT = 600000;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [6:0]  idx;
        logic [15:0] coeff;
        logic        err;
    } tap_result_t;

    // expected coefficients, oldest first
    class coeff_scoreboard;
        tap_result_t pending[$];
        int errors;
        int checked;
        logic [7:0]  taps;
        logic [15:0] f_low;
        logic [15:0] f_high;

        function new();
            errors = 0;
            checked = 0;
            taps = 8'd64;
            f_low = 16'd0;
            f_high = 16'd16384;
        endfunction

        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function void rotate(logic [31:0] phase, output longint s, output longint c);
            logic flip;
            logic [31:0] p;
            longint z, x, y, dx, dy;
            flip = ((phase + 32'h4000_0000) & 32'h8000_0000) != 0;
            p = flip ? phase + 32'h8000_0000 : phase;
            z = p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
            x = longint'(CORDIC_GAIN);
            y = 0;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                dx = fshift(y, k);
                dy = fshift(x, k);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint sinc_sine(logic [15:0] f, longint m);
            logic [63:0] ph;
            longint s, c;
            ph = (64'(f) * 64'(m)) << 15;
            rotate(ph[31:0], s, c);
            return s;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] value);
            case (index)
                REG_TAP_COUNT: taps = value[7:0];
                REG_LOW_CUTOFF: f_low = value;
                REG_HIGH_CUTOFF: f_high = value;
                default: ;
            endcase
        endfunction

        function void note_tap(logic [6:0] i);
            tap_result_t r;
            longint L, fl, fh, m, h, w, q, d, s1, c1, s2, c2;
            logic [63:0] ph1, ph2;
            L = (taps > TAPS_LIMIT) ? longint'(TAPS_LIMIT) : longint'(taps);
            fl = (f_low > CUTOFF_MAX) ? longint'(CUTOFF_MAX) : longint'(f_low);
            fh = (f_high > CUTOFF_MAX) ? longint'(CUTOFF_MAX) : longint'(f_high);
            r.idx = i;
            r.err = 1'b0;
            r.coeff = '0;
            if (longint'(i) >= L)
                r.err = 1'b1;
            else
            begin
                m = 2 * longint'(i) - (L - 1);
                if (m == 0)
                    h = (fh - fl) * 32768;
                else
                begin
                    d = sinc_sine(fh[15:0], m) - sinc_sine(fl[15:0], m);
                    h = (2 * d * longint'(INV_PI)) / (m * (64'sd1 << 30));
                end
                if (L == 1)
                    w = 64'sd1 << 30;
                else
                begin
                    ph1 = (64'(i) << 32) / 64'(L - 1);
                    ph2 = ph1 << 1;
                    rotate(ph1[31:0], s1, c1);
                    rotate(ph2[31:0], s2, c2);
                    w = longint'(W_A0) - fshift(c1, 1) + fshift(c2 * longint'(W_A2), 30);
                end
                q = fshift(h * w + (64'sd1 << (60 - CWIDTH)), 61 - CWIDTH);
                if (q > 32767) q = 32767;
                if (q < -32768) q = -32768;
                r.coeff = q[15:0];
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [6:0] idx, logic [15:0] coeff, logic err);
            tap_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result: tap_index_out %0d", idx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx)
            begin
                $error("tap_index_out: expected %0d, got %0d", e.idx, idx);
                errors++;
            end
            if (coeff !== e.coeff)
            begin
                $error("coefficient: expected %0d, got %0d", $signed(e.coeff), $signed(coeff));
                errors++;
            end
            if (err !== e.err)
            begin
                $error("index_error: expected %0d, got %0d", e.err, err);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [6:0] tap_index;
    logic out_valid;
    logic out_stall;
    logic [6:0] tap_index_out;
    logic signed [15:0] coefficient;
    logic index_error;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    coeff_scoreboard sb;
    longint cycles;
    int sent;
    bit draining;

    windowed_sinc_bandpass_coeff_gen u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .tap_index(tap_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .tap_index_out(tap_index_out), .coefficient(coefficient),
        .index_error(index_error),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: stall for random stretches, check on every accepted result
    initial
    begin
        int g;
        int hold;
        out_stall = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(tap_index_out, coefficient, index_error);
            if (draining)
                out_stall <= 1'b0;
            else if (hold > 0)
                hold--;
            else
            begin
                g = gap_len();
                hold = (g > 0) ? g - 1 : 0;
                out_stall <= (g != 0);
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic send_tap(logic [6:0] i);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        tap_index <= i;
        do @(posedge clk); while (in_stall);
        sb.note_tap(i);
        sent++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] index, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(index, value);
    endtask

    task automatic set_filter(logic [15:0] L, logic [15:0] lo, logic [15:0] hi);
        set_reg(REG_TAP_COUNT, L);
        set_reg(REG_LOW_CUTOFF, lo);
        set_reg(REG_HIGH_CUTOFF, hi);
    endtask

    task automatic random_cutoffs(output logic [15:0] lo, output logic [15:0] hi);
        int r;
        r = $urandom_range(0, 9);
        lo = 16'($urandom_range(0, 16384));
        hi = 16'($urandom_range(lo, 32768));
        if (r == 0) lo = 16'($urandom);
        if (r == 1) hi = 16'($urandom);
        if (r == 2)
        begin
            lo = 16'($urandom_range(8000, 32768));
            hi = 16'($urandom_range(0, 8000));
        end
    endtask

    initial
    begin
        logic [15:0] L, lo, hi;
        int n;
        sb = new();
        sent = 0;
        draining = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        tap_index = '0;
        cfg_write = 1'b0;
        cfg_index = REG_TAP_COUNT;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: both ends, the two middle taps, one beyond the end and the last index
        send_tap(7'd0); send_tap(7'd31); send_tap(7'd32); send_tap(7'd63);
        send_tap(7'd64); send_tap(7'd127);
        go_idle();
        // full-range cutoffs at the largest tap count
        set_filter(16'd128, 16'd0, 16'd32768);
        send_tap(7'd0); send_tap(7'd64); send_tap(7'd127);
        go_idle();
        // single tap, oversized, zero, two and three taps, saturated, inverted and zero cutoffs, unused register
        set_filter(16'd1, 16'd1000, 16'd30000);
        send_tap(7'd0); send_tap(7'd1);
        go_idle();
        set_filter(16'd255, 16'hffff, 16'hffff);
        send_tap(7'd127); send_tap(7'd5);
        go_idle();
        set_filter(16'd0, 16'd20000, 16'd4000);
        send_tap(7'd0); send_tap(7'd85);
        go_idle();
        set_filter(16'd2, 16'd30000, 16'd2000);
        send_tap(7'd0); send_tap(7'd1); send_tap(7'd2);
        go_idle();
        set_filter(16'd3, 16'd0, 16'd0);
        send_tap(7'd1); send_tap(7'd42);
        go_idle();
        set_reg(REG_NONE, 16'h1234);
        send_tap(7'd2);
        go_idle();

        while (sent < 1120)
        begin
            case ($urandom_range(0, 5))
                0: L = 16'd128;
                1: L = 16'($urandom_range(1, 4));
                2: L = 16'($urandom_range(129, 65535));
                3: L = 16'($urandom_range(0, 255));
                default: L = 16'($urandom_range(1, 128));
            endcase
            random_cutoffs(lo, hi);
            set_filter(L, lo, hi);
            n = $urandom_range(20, 90);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_tap(7'($urandom));
                else if (L > 0 && L <= 128)
                    send_tap(7'($urandom_range(0, L - 1)));
                else
                    send_tap(7'($urandom_range(0, 127)));
            end
            go_idle();
        end

        draining = 1;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d tap coefficients over random tap counts and cutoffs,",
                 sb.checked);
        $display("including single tap, zero taps, inverted and saturated bands.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
